// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used across the core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/spd_pkg.sv -----
// ----------------------------------------------------------------------------
// spd_pkg
// Constants, operation codes and shared types of the slot directory core.
// ----------------------------------------------------------------------------
package spd_pkg;

   localparam int PAGE_BYTES   = 4096;
   localparam int HEADER_BYTES = 8;
   localparam int SLOT_BYTES   = 4;
   localparam int MAX_SLOTS    = 1024;

   // Port field widths
   localparam int OP_W   = 3;
   localparam int SLOT_W = 10;
   localparam int SIZE_W = 12;
   localparam int OFF_W  = 12;

   // Internal widths
   localparam int PTR_W     = $clog2(PAGE_BYTES) + 1;  // holds PAGE_BYTES itself
   localparam int SOFF_W    = PTR_W;                   // stored offset, may equal page end
   localparam int TOTAL_W   = $clog2(MAX_SLOTS) + 1;
   localparam int ADDR_W    = $clog2(MAX_SLOTS);
   localparam int IDX_CMP_W = (TOTAL_W > SLOT_W) ? TOTAL_W : SLOT_W;
   localparam int ENTRY_W   = SOFF_W + SIZE_W;

   typedef enum logic [OP_W-1:0] {
      OP_INIT      = 3'd0,
      OP_INSERT    = 3'd1,
      OP_INSERT_AT = 3'd2,
      OP_READ      = 3'd3,
      OP_DELETE    = 3'd4
   } op_type;

   typedef struct packed {
      logic                ok;
      logic [SLOT_W-1:0]   slot_result;
      logic [OFF_W-1:0]    record_offset;
      logic [SIZE_W-1:0]   record_length;
      logic [SLOT_W-1:0]   record_count;
      logic [OFF_W-1:0]    free_bytes;
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic [SOFF_W-1:0]   wr_offset;
      logic [SIZE_W-1:0]   wr_size;
      logic [TOTAL_W-1:0]  total_next;
      logic [PTR_W-1:0]    start_next;
      logic [PTR_W-1:0]    end_next;
   } decision_type;

endpackage

// ----- rtl/core/spd_ram.sv -----
// ----------------------------------------------------------------------------
// spd_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module spd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/spd_eval.sv -----
// ----------------------------------------------------------------------------
// spd_eval
// Checks one operation against the page header and the slot entry read
// back from the table, and works out write-back and next header values.
// ----------------------------------------------------------------------------
module spd_eval (
   input  logic [spd_pkg::OP_W-1:0]    op,
   input  logic [spd_pkg::SLOT_W-1:0]  idx,
   input  logic [spd_pkg::SIZE_W-1:0]  size,
   input  logic [spd_pkg::TOTAL_W-1:0] total,
   input  logic [spd_pkg::PTR_W-1:0]   free_start,
   input  logic [spd_pkg::PTR_W-1:0]   free_end,
   input  logic [spd_pkg::SOFF_W-1:0]  rd_offset,
   input  logic [spd_pkg::SIZE_W-1:0]  rd_size,
   output spd_pkg::decision_type       dec
);

   logic [spd_pkg::PTR_W-1:0] space;
   logic [spd_pkg::PTR_W-1:0] size_ext;
   logic [spd_pkg::PTR_W-1:0] need_new;
   logic [spd_pkg::PTR_W-1:0] new_off;
   logic [spd_pkg::PTR_W-1:0] space_after;
   logic                      idx_live;
   logic                      slot_used;
   logic                      room_slot;
   logic                      room_new;

   assign space     = (free_end >= free_start) ? (free_end - free_start) : '0;
   assign size_ext  = spd_pkg::PTR_W'(size);
   assign need_new  = spd_pkg::PTR_W'(spd_pkg::SLOT_BYTES) + size_ext;
   assign new_off   = free_end - size_ext;
   assign idx_live  = spd_pkg::IDX_CMP_W'(idx) < spd_pkg::IDX_CMP_W'(total);
   assign slot_used = idx_live && (rd_size != '0);
   assign room_new  = (total < spd_pkg::TOTAL_W'(spd_pkg::MAX_SLOTS)) && (space >= need_new);
   assign room_slot = idx_live && (rd_size == '0) && (space >= size_ext);

   always_comb begin
      dec               = '0;
      dec.slot_result   = idx;
      dec.wr_addr       = spd_pkg::ADDR_W'(idx);
      dec.total_next    = total;
      dec.start_next    = free_start;
      dec.end_next      = free_end;

      unique case (spd_pkg::op_type'(op))
         spd_pkg::OP_INIT: begin
            dec.ok         = 1'b1;
            dec.total_next = '0;
            dec.start_next = spd_pkg::PTR_W'(spd_pkg::HEADER_BYTES);
            dec.end_next   = spd_pkg::PTR_W'(spd_pkg::PAGE_BYTES);
         end
         spd_pkg::OP_INSERT: begin
            if (room_new) begin
               dec.ok            = 1'b1;
               dec.slot_result   = spd_pkg::SLOT_W'(total);
               dec.record_offset = spd_pkg::OFF_W'(new_off);
               dec.record_length = size;
               dec.wr_en         = 1'b1;
               dec.wr_addr       = total[spd_pkg::ADDR_W-1:0];
               dec.wr_offset     = spd_pkg::SOFF_W'(new_off);
               dec.wr_size       = size;
               dec.total_next    = total + 1'b1;
               dec.start_next    = free_start + spd_pkg::PTR_W'(spd_pkg::SLOT_BYTES);
               dec.end_next      = new_off;
            end
         end
         spd_pkg::OP_INSERT_AT: begin
            if (room_slot) begin
               dec.ok            = 1'b1;
               dec.record_offset = spd_pkg::OFF_W'(new_off);
               dec.record_length = size;
               dec.wr_en         = 1'b1;
               dec.wr_offset     = spd_pkg::SOFF_W'(new_off);
               dec.wr_size       = size;
               dec.end_next      = new_off;
            end
         end
         spd_pkg::OP_READ: begin
            if (slot_used) begin
               dec.ok            = 1'b1;
               dec.record_offset = spd_pkg::OFF_W'(rd_offset);
               dec.record_length = rd_size;
            end
         end
         spd_pkg::OP_DELETE: begin
            if (slot_used) begin
               dec.ok    = 1'b1;
               dec.wr_en = 1'b1;  // offset and size written as zero
            end
         end
         default: begin
         end
      endcase

      // end never falls below start: a slot is charged only when room exists
      space_after = (dec.end_next >= dec.start_next) ?
                    (dec.end_next - dec.start_next) : '0;

      dec.record_count = spd_pkg::SLOT_W'(dec.total_next);
      dec.free_bytes   = spd_pkg::OFF_W'(space_after);
   end

endmodule

// ----- rtl/core/slotted_page_directory_top.sv -----
// ----------------------------------------------------------------------------
// slotted_page_directory_top
// Slot directory manager for one slotted page: record count, free-space
// pointers and a per-slot offset/size table.
// ----------------------------------------------------------------------------
// For every item, the edge of acceptance reads the slot entry from the
// table RAM, and the following cycle, with busy high, checks it, writes
// the entry back and updates the header registers. The result appears on
// the rsp_ ports for one cycle with rsp_strobe high, the first cycle with
// busy low again, and must be captured at the edge ending it, as it is not
// held. A new item may be accepted at that same edge; none is taken while
// busy is high.
// The table is not cleared at reset; slots are only reachable once written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slotted_page_directory_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [spd_pkg::OP_W-1:0]    req_operation,
   input  logic [spd_pkg::SLOT_W-1:0]  req_slot_index,
   input  logic [spd_pkg::SIZE_W-1:0]  req_record_size,
   output logic                        rsp_strobe,
   output logic                        rsp_ok,
   output logic [spd_pkg::SLOT_W-1:0]  rsp_slot_result,
   output logic [spd_pkg::OFF_W-1:0]   rsp_record_offset,
   output logic [spd_pkg::SIZE_W-1:0]  rsp_record_length,
   output logic [spd_pkg::SLOT_W-1:0]  rsp_record_count,
   output logic [spd_pkg::OFF_W-1:0]   rsp_free_bytes
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type                   state_ff, state_in;
   logic                        accept;

   logic [spd_pkg::OP_W-1:0]    op_ff;
   logic [spd_pkg::SLOT_W-1:0]  idx_ff;
   logic [spd_pkg::SIZE_W-1:0]  size_ff;

   logic [spd_pkg::TOTAL_W-1:0] total_ff;
   logic [spd_pkg::PTR_W-1:0]   start_ff;
   logic [spd_pkg::PTR_W-1:0]   end_ff;

   logic                        strobe_ff;
   logic                        ok_ff;
   logic [spd_pkg::SLOT_W-1:0]  slot_ff;
   logic [spd_pkg::OFF_W-1:0]   offset_ff;
   logic [spd_pkg::SIZE_W-1:0]  length_ff;
   logic [spd_pkg::SLOT_W-1:0]  count_ff;
   logic [spd_pkg::OFF_W-1:0]   free_ff;

   logic [spd_pkg::ENTRY_W-1:0] rd_entry;
   logic [spd_pkg::ENTRY_W-1:0] wr_entry;
   logic                        exec;
   spd_pkg::decision_type       dec;

   assign accept   = start && (state_ff == ST_IDLE);
   assign exec     = (state_ff == ST_EXEC);
   assign state_in = accept ? ST_EXEC : ST_IDLE;
   assign wr_entry = {dec.wr_offset, dec.wr_size};

   spd_ram #(
      .WIDTH (spd_pkg::ENTRY_W),
      .DEPTH (spd_pkg::MAX_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (exec && dec.wr_en),
      .wr_addr (dec.wr_addr),
      .wr_data (wr_entry),
      .rd_en   (accept),
      .rd_addr (spd_pkg::ADDR_W'(req_slot_index)),
      .rd_data (rd_entry)
   );

   spd_eval u_eval (
      .op         (op_ff),
      .idx        (idx_ff),
      .size       (size_ff),
      .total      (total_ff),
      .free_start (start_ff),
      .free_end   (end_ff),
      .rd_offset  (rd_entry[spd_pkg::ENTRY_W-1:spd_pkg::SIZE_W]),
      .rd_size    (rd_entry[spd_pkg::SIZE_W-1:0]),
      .dec        (dec)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         total_ff  <= '0;
         start_ff  <= spd_pkg::PTR_W'(spd_pkg::HEADER_BYTES);
         end_ff    <= spd_pkg::PTR_W'(spd_pkg::PAGE_BYTES);
      end else begin
         state_ff  <= state_in;
         strobe_ff <= exec;
         if (exec) begin
            total_ff  <= dec.total_next;
            start_ff  <= dec.start_next;
            end_ff    <= dec.end_next;
            ok_ff     <= dec.ok;
            slot_ff   <= dec.slot_result;
            offset_ff <= dec.record_offset;
            length_ff <= dec.record_length;
            count_ff  <= dec.record_count;
            free_ff   <= dec.free_bytes;
         end
      end
   end

   // Item payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_operation;
         idx_ff  <= req_slot_index;
         size_ff <= req_record_size;
      end
   end

   assign busy              = exec;
   assign rsp_strobe        = strobe_ff;
   assign rsp_ok            = ok_ff;
   assign rsp_slot_result   = slot_ff;
   assign rsp_record_offset = offset_ff;
   assign rsp_record_length = length_ff;
   assign rsp_record_count  = count_ff;
   assign rsp_free_bytes    = free_ff;

   `ASSERT_NEXT(a_accept_exec, clock, reset, accept, exec && !rsp_strobe, "accepted item did not enter execution")
   `ASSERT_NEXT(a_exec_result, clock, reset, exec, rsp_strobe && !exec, "execution did not end in a result")
   `ASSERT_IMPLIES(a_ptr_order, clock, reset, 1'b1, end_ff >= start_ff, "free end fell below free start")
   `ASSERT_IMPLIES(a_total_max, clock, reset, 1'b1, total_ff <= spd_pkg::TOTAL_W'(spd_pkg::MAX_SLOTS), "slot count beyond table depth")

endmodule

// ----- sim/tb_slotted_page_directory_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_slotted_page_directory_top
// Self-checking bench for the slot directory manager. A short scripted run
// covers the failure codes, zero-length records and a completely full page.
// It is followed by randomised episodes, each opened by an initialise: mixed
// traffic, one long stretch with the sender never pausing, and one dense fill
// that pushes the record count past 512. Every result is compared field by
// field against a shadow copy of the directory state or a pinned script value.
// ----------------------------------------------------------------------------
module tb_slotted_page_directory_top;
   import spd_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 10;
   localparam int RANDOM_ITEMS = 1300;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int PRINT_LIMIT  = 50;
   localparam int SCRIPT_ROWS  = 25;

   // codes the block does not decode
   localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

   typedef struct packed {
      logic              ok;
      logic [SLOT_W-1:0] slot;
      logic [OFF_W-1:0]  offset;
      logic [SIZE_W-1:0] length;
      logic [SLOT_W-1:0] count;
      logic [OFF_W-1:0]  room;
   } page_result_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [SLOT_W-1:0] idx;
      logic [SIZE_W-1:0] size;
      logic              pinned;
      page_result_type   want;
   } script_row_type;

   localparam page_result_type NO_PIN = '0;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [OP_W-1:0]     req_operation;
   logic [SLOT_W-1:0]   req_slot_index;
   logic [SIZE_W-1:0]   req_record_size;
   logic                rsp_strobe;
   logic                rsp_ok;
   logic [SLOT_W-1:0]   rsp_slot_result;
   logic [OFF_W-1:0]    rsp_record_offset;
   logic [SIZE_W-1:0]   rsp_record_length;
   logic [SLOT_W-1:0]   rsp_record_count;
   logic [OFF_W-1:0]    rsp_free_bytes;

   // shadow of the directory
   logic [SOFF_W-1:0]   shadow_offset [MAX_SLOTS];
   logic [SIZE_W-1:0]   shadow_size [MAX_SLOTS];
   logic [TOTAL_W-1:0]  shadow_count;
   logic [PTR_W-1:0]    shadow_start;
   logic [PTR_W-1:0]    shadow_end;

   page_result_type     pending_results[$];
   page_result_type     oldest;
   script_row_type      script [SCRIPT_ROWS];
   int                  mismatches;
   int unsigned         cycle_count;
   bit                  quiet;

   slotted_page_directory_top dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_slot_index    (req_slot_index),
      .req_record_size   (req_record_size),
      .rsp_strobe        (rsp_strobe),
      .rsp_ok            (rsp_ok),
      .rsp_slot_result   (rsp_slot_result),
      .rsp_record_offset (rsp_record_offset),
      .rsp_record_length (rsp_record_length),
      .rsp_record_count  (rsp_record_count),
      .rsp_free_bytes    (rsp_free_bytes)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   task automatic flag_mismatch(input string what);
      if (mismatches < PRINT_LIMIT)
         $display("%0t mismatch: %s", $time, what);
      mismatches++;
   endtask

   function automatic logic [PTR_W-1:0] shadow_room();
      return (shadow_end >= shadow_start) ? shadow_end - shadow_start : '0;
   endfunction

   function automatic bit slot_live(input logic [SLOT_W-1:0] idx);
      return idx < shadow_count && shadow_size[idx] != '0;
   endfunction

   function automatic page_result_type predict_page_op(input logic [OP_W-1:0] op,
         input logic [SLOT_W-1:0] idx, input logic [SIZE_W-1:0] size);
      page_result_type  res;
      logic [PTR_W-1:0] room;
      logic [PTR_W-1:0] place;
      room = shadow_room();
      res = '0;
      res.slot = idx;
      case (op)
         OP_INIT: begin
            shadow_count = '0;
            shadow_start = PTR_W'(HEADER_BYTES);
            shadow_end   = PTR_W'(PAGE_BYTES);
            res.ok = 1'b1;
         end
         OP_INSERT: begin
            if (shadow_count < MAX_SLOTS && room >= SLOT_BYTES + size) begin
               place = shadow_end - size;
               shadow_offset[shadow_count[ADDR_W-1:0]] = place;
               shadow_size[shadow_count[ADDR_W-1:0]] = size;
               res.slot = shadow_count[SLOT_W-1:0];
               shadow_count = shadow_count + 1'b1;
               shadow_start = shadow_start + PTR_W'(SLOT_BYTES);
               shadow_end = place;
               res.ok = 1'b1;
               res.offset = place[OFF_W-1:0];
               res.length = size;
            end
         end
         OP_INSERT_AT: begin
            // refill only a deleted or zero-length slot; no slot space charged
            if (idx < shadow_count && room >= size && shadow_size[idx] == '0) begin
               place = shadow_end - size;
               shadow_offset[idx] = place;
               shadow_size[idx] = size;
               shadow_end = place;
               res.ok = 1'b1;
               res.offset = place[OFF_W-1:0];
               res.length = size;
            end
         end
         OP_READ: begin
            if (slot_live(idx)) begin
               res.ok = 1'b1;
               res.offset = shadow_offset[idx][OFF_W-1:0];
               res.length = shadow_size[idx];
            end
         end
         OP_DELETE: begin
            if (slot_live(idx)) begin
               shadow_offset[idx] = '0;
               shadow_size[idx] = '0;
               res.ok = 1'b1;
            end
         end
         default: ;
      endcase
      room = shadow_room();
      res.count = shadow_count[SLOT_W-1:0];
      res.room = room[OFF_W-1:0];
      return res;
   endfunction

   // Presents one item, holds it until taken, then logs what it should give.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] idx,
         input logic [SIZE_W-1:0] size, input logic pinned, input page_result_type pin);
      page_result_type want;
      if (!quiet && $urandom_range(0, 99) < 10) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
      @(negedge clock);
      start           <= 1'b1;
      req_operation   <= op;
      req_slot_index  <= idx;
      req_record_size <= size;
      do @(posedge clock); while (busy);
      want = predict_page_op(op, idx, size);
      if (pinned)
         want = pin;
      pending_results.push_back(want);
   endtask

   function automatic logic [SLOT_W-1:0] live_slot();
      if (shadow_count == '0)
         return SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
      return SLOT_W'($urandom_range(0, shadow_count - 1));
   endfunction

   function automatic logic [SLOT_W-1:0] empty_slot();
      logic [SLOT_W-1:0] idx;
      idx = live_slot();
      for (int t = 0; t < 8 && shadow_size[idx] != '0; t++)
         idx = live_slot();
      return idx;
   endfunction

   task automatic pick_item(input bit dense, output logic [OP_W-1:0] op,
         output logic [SLOT_W-1:0] idx, output logic [SIZE_W-1:0] size);
      int dice;
      int band;
      dice = $urandom_range(0, 99);
      band = $urandom_range(0, 9);
      idx  = live_slot();
      size = '0;
      if (dense) begin
         if (dice < 80) begin
            op = OP_INSERT;
            size = SIZE_W'($urandom_range(0, 3));
         end else if (dice < 90) begin
            op = OP_READ;
         end else if (dice < 95) begin
            op = OP_DELETE;
         end else begin
            op = OP_INSERT_AT;
            idx = empty_slot();
            size = SIZE_W'($urandom_range(0, 3));
         end
      end else if (dice < 35) begin
         op = OP_INSERT;
         idx = SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
         size = SIZE_W'((band < 7) ? $urandom_range(0, 120) :
                (band < 9) ? $urandom_range(0, 600) : $urandom_range(0, 4095));
      end else if (dice < 55) begin
         op = OP_READ;
      end else if (dice < 68) begin
         op = OP_DELETE;
      end else if (dice < 80) begin
         op = OP_INSERT_AT;
         idx = empty_slot();
         size = SIZE_W'((band < 8) ? $urandom_range(0, 200) : $urandom_range(0, 4095));
      end else if (dice < 90) begin
         // noise: any code, any index, any size
         op = OP_W'($urandom_range(0, 7));
         idx = SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
         size = SIZE_W'($urandom_range(0, 4095));
      end else begin
         op = (band < 5) ? OP_READ : (band < 8) ? OP_DELETE : OP_INSERT_AT;
         idx = SLOT_W'($urandom_range(shadow_count, MAX_SLOTS - 1));
         size = SIZE_W'($urandom_range(0, 4095));
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            flag_mismatch($sformatf("result with nothing pending, slot %0d",
                                    rsp_slot_result));
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_ok !== oldest.ok)
               flag_mismatch($sformatf("ok %0b want %0b", rsp_ok, oldest.ok));
            if (rsp_slot_result !== oldest.slot)
               flag_mismatch($sformatf("slot %0d want %0d", rsp_slot_result, oldest.slot));
            if (rsp_record_offset !== oldest.offset)
               flag_mismatch($sformatf("offset %0d want %0d", rsp_record_offset,
                                       oldest.offset));
            if (rsp_record_length !== oldest.length)
               flag_mismatch($sformatf("length %0d want %0d", rsp_record_length,
                                       oldest.length));
            if (rsp_record_count !== oldest.count)
               flag_mismatch($sformatf("count %0d want %0d", rsp_record_count,
                                       oldest.count));
            if (rsp_free_bytes !== oldest.room)
               flag_mismatch($sformatf("free bytes %0d want %0d", rsp_free_bytes,
                                       oldest.room));
         end
      end
   end

   initial begin
      logic [OP_W-1:0]   op;
      logic [SLOT_W-1:0] idx;
      logic [SIZE_W-1:0] size;
      int                sent;
      int                episode;
      int                span;
      bit                dense;

      reset           = 1'b1;
      start           = 1'b0;
      req_operation   = OP_INIT;
      req_slot_index  = '0;
      req_record_size = '0;
      mismatches      = 0;
      cycle_count     = 0;
      quiet           = 1'b0;
      shadow_count    = '0;
      shadow_start    = PTR_W'(HEADER_BYTES);
      shadow_end      = PTR_W'(PAGE_BYTES);
      for (int i = 0; i < MAX_SLOTS; i++) begin
         shadow_offset[i] = '0;
         shadow_size[i]   = '0;
      end

      script = '{
         // failures straight out of reset, then an initialise
         '{OP_READ,      10'd0,     12'd0,     1'b1, '{1'b0, 10'd0,   12'd0, 12'd0, 10'd0, 12'd4088}},
         '{OP_SPARE_LO,  10'd1023,  12'd4095,  1'b1, '{1'b0, 10'd1023,12'd0, 12'd0, 10'd0, 12'd4088}},
         '{OP_SPARE_MID, 10'h2AA,   12'hAAA,   1'b1, '{1'b0, 10'h2AA, 12'd0, 12'd0, 10'd0, 12'd4088}},
         '{OP_SPARE_HI,  10'h155,   12'h555,   1'b1, '{1'b0, 10'h155, 12'd0, 12'd0, 10'd0, 12'd4088}},
         '{OP_INIT,      10'd1023,  12'd4095,  1'b1, '{1'b1, 10'd1023,12'd0, 12'd0, 10'd0, 12'd4088}},
         // zero-length record sits at the page end, offset wraps to 0
         '{OP_INSERT,    10'd7,     12'd0,     1'b1, '{1'b1, 10'd0,   12'd0, 12'd0, 10'd1, 12'd4084}},
         '{OP_READ,      10'd0,     12'd0,     1'b1, '{1'b0, 10'd0,   12'd0, 12'd0, 10'd1, 12'd4084}},
         '{OP_INSERT_AT, 10'd0,     12'd100,   1'b0, NO_PIN},
         '{OP_INSERT_AT, 10'd0,     12'd5,     1'b0, NO_PIN},
         '{OP_READ,      10'd0,     12'd0,     1'b0, NO_PIN},
         '{OP_DELETE,    10'd0,     12'd0,     1'b0, NO_PIN},
         '{OP_DELETE,    10'd0,     12'd0,     1'b0, NO_PIN},
         '{OP_INSERT_AT, 10'd1,     12'd1,     1'b0, NO_PIN},
         '{OP_INSERT,    10'd0,     12'd4095,  1'b0, NO_PIN},
         '{OP_INSERT,    10'd0,     12'd3000,  1'b0, NO_PIN},
         '{OP_READ,      10'd1,     12'd0,     1'b0, NO_PIN},
         // one record filling the page exactly
         '{OP_INIT,      10'd0,     12'd0,     1'b1, '{1'b1, 10'd0,   12'd0, 12'd0, 10'd0, 12'd4088}},
         '{OP_INSERT,    10'd0,     12'd4084,  1'b1, '{1'b1, 10'd0,  12'd12, 12'd4084, 10'd1, 12'd0}},
         '{OP_INSERT,    10'h200,   12'd0,     1'b1, '{1'b0, 10'h200, 12'd0, 12'd0, 10'd1, 12'd0}},
         '{OP_READ,      10'd0,     12'd0,     1'b1, '{1'b1, 10'd0,  12'd12, 12'd4084, 10'd1, 12'd0}},
         '{OP_DELETE,    10'd0,     12'd0,     1'b1, '{1'b1, 10'd0,   12'd0, 12'd0, 10'd1, 12'd0}},
         '{OP_INSERT_AT, 10'd0,     12'd0,     1'b0, NO_PIN},
         '{OP_READ,      10'd1023,  12'd0,     1'b0, NO_PIN},
         '{OP_DELETE,    10'd1023,  12'd0,     1'b0, NO_PIN},
         '{OP_INIT,      10'd0,     12'd0,     1'b1, '{1'b1, 10'd0,   12'd0, 12'd0, 10'd0, 12'd4088}}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[r])
         send_item(script[r].op, script[r].idx, script[r].size, script[r].pinned,
                   script[r].want);

      sent = 0;
      episode = 0;
      while (sent < RANDOM_ITEMS) begin
         dense = (episode == 2);
         quiet = (episode == 1);
         span = dense ? 700 : quiet ? 150 : $urandom_range(40, 120);
         send_item(OP_INIT, SLOT_W'($urandom_range(0, MAX_SLOTS - 1)),
                   SIZE_W'($urandom_range(0, 4095)), 1'b0, NO_PIN);
         sent++;
         for (int k = 0; k < span && !(dense && shadow_count >= 560); k++) begin
            pick_item(dense, op, idx, size);
            send_item(op, idx, size, 1'b0, NO_PIN);
            sent++;
         end
         episode++;
      end
      quiet = 1'b0;

      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- slotted_page_directory_top.f -----
+incdir+rtl/core
rtl/core/spd_pkg.sv
rtl/core/spd_ram.sv
rtl/core/spd_eval.sv
rtl/core/slotted_page_directory_top.sv
sim/tb_slotted_page_directory_top.sv
